// ----- rtl/u8cw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8cw_pkg: shared types and tables for the UTF-8 column width decoder
// Holds the work record between front and back, and the combining ROM.
// ----------------------------------------------------------------------------
package u8cw_pkg;

   localparam int CpWidth    = 21;
   localparam int RomDepth   = 123;
   localparam int RomIdxBits = 7;
   localparam int QueueDepth = 2;

   // decoded character handed from the decoder front to the width back end
   typedef struct packed {
      logic               err;
      logic [CpWidth-1:0] cp;
      logic [2:0]         len;
   } work_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SEARCH,
      BK_DONE
   } back_state_type;

   function automatic logic [2*CpWidth-1:0] rom_entry(input logic [RomIdxBits-1:0] idx);
      logic [2*CpWidth-1:0] e;
      e = '0;
      case (idx)
         7'd0: e = {21'h0300, 21'h0357};  7'd1: e = {21'h035D, 21'h036F};
         7'd2: e = {21'h0483, 21'h0486};  7'd3: e = {21'h0488, 21'h0489};
         7'd4: e = {21'h0591, 21'h05A1};  7'd5: e = {21'h05A3, 21'h05B9};
         7'd6: e = {21'h05BB, 21'h05BD};  7'd7: e = {21'h05BF, 21'h05BF};
         7'd8: e = {21'h05C1, 21'h05C2};  7'd9: e = {21'h05C4, 21'h05C4};
         7'd10: e = {21'h0600, 21'h0603}; 7'd11: e = {21'h0610, 21'h0615};
         7'd12: e = {21'h064B, 21'h0658}; 7'd13: e = {21'h0670, 21'h0670};
         7'd14: e = {21'h06D6, 21'h06E4}; 7'd15: e = {21'h06E7, 21'h06E8};
         7'd16: e = {21'h06EA, 21'h06ED}; 7'd17: e = {21'h070F, 21'h070F};
         7'd18: e = {21'h0711, 21'h0711}; 7'd19: e = {21'h0730, 21'h074A};
         7'd20: e = {21'h07A6, 21'h07B0}; 7'd21: e = {21'h0901, 21'h0902};
         7'd22: e = {21'h093C, 21'h093C}; 7'd23: e = {21'h0941, 21'h0948};
         7'd24: e = {21'h094D, 21'h094D}; 7'd25: e = {21'h0951, 21'h0954};
         7'd26: e = {21'h0962, 21'h0963}; 7'd27: e = {21'h0981, 21'h0981};
         7'd28: e = {21'h09BC, 21'h09BC}; 7'd29: e = {21'h09C1, 21'h09C4};
         7'd30: e = {21'h09CD, 21'h09CD}; 7'd31: e = {21'h09E2, 21'h09E3};
         7'd32: e = {21'h0A01, 21'h0A02}; 7'd33: e = {21'h0A3C, 21'h0A3C};
         7'd34: e = {21'h0A41, 21'h0A42}; 7'd35: e = {21'h0A47, 21'h0A48};
         7'd36: e = {21'h0A4B, 21'h0A4D}; 7'd37: e = {21'h0A70, 21'h0A71};
         7'd38: e = {21'h0A81, 21'h0A82}; 7'd39: e = {21'h0ABC, 21'h0ABC};
         7'd40: e = {21'h0AC1, 21'h0AC5}; 7'd41: e = {21'h0AC7, 21'h0AC8};
         7'd42: e = {21'h0ACD, 21'h0ACD}; 7'd43: e = {21'h0AE2, 21'h0AE3};
         7'd44: e = {21'h0B01, 21'h0B01}; 7'd45: e = {21'h0B3C, 21'h0B3C};
         7'd46: e = {21'h0B3F, 21'h0B3F}; 7'd47: e = {21'h0B41, 21'h0B43};
         7'd48: e = {21'h0B4D, 21'h0B4D}; 7'd49: e = {21'h0B56, 21'h0B56};
         7'd50: e = {21'h0B82, 21'h0B82}; 7'd51: e = {21'h0BC0, 21'h0BC0};
         7'd52: e = {21'h0BCD, 21'h0BCD}; 7'd53: e = {21'h0C3E, 21'h0C40};
         7'd54: e = {21'h0C46, 21'h0C48}; 7'd55: e = {21'h0C4A, 21'h0C4D};
         7'd56: e = {21'h0C55, 21'h0C56}; 7'd57: e = {21'h0CBC, 21'h0CBC};
         7'd58: e = {21'h0CBF, 21'h0CBF}; 7'd59: e = {21'h0CC6, 21'h0CC6};
         7'd60: e = {21'h0CCC, 21'h0CCD}; 7'd61: e = {21'h0D41, 21'h0D43};
         7'd62: e = {21'h0D4D, 21'h0D4D}; 7'd63: e = {21'h0DCA, 21'h0DCA};
         7'd64: e = {21'h0DD2, 21'h0DD4}; 7'd65: e = {21'h0DD6, 21'h0DD6};
         7'd66: e = {21'h0E31, 21'h0E31}; 7'd67: e = {21'h0E34, 21'h0E3A};
         7'd68: e = {21'h0E47, 21'h0E4E}; 7'd69: e = {21'h0EB1, 21'h0EB1};
         7'd70: e = {21'h0EB4, 21'h0EB9}; 7'd71: e = {21'h0EBB, 21'h0EBC};
         7'd72: e = {21'h0EC8, 21'h0ECD}; 7'd73: e = {21'h0F18, 21'h0F19};
         7'd74: e = {21'h0F35, 21'h0F35}; 7'd75: e = {21'h0F37, 21'h0F37};
         7'd76: e = {21'h0F39, 21'h0F39}; 7'd77: e = {21'h0F71, 21'h0F7E};
         7'd78: e = {21'h0F80, 21'h0F84}; 7'd79: e = {21'h0F86, 21'h0F87};
         7'd80: e = {21'h0F90, 21'h0F97}; 7'd81: e = {21'h0F99, 21'h0FBC};
         7'd82: e = {21'h0FC6, 21'h0FC6}; 7'd83: e = {21'h102D, 21'h1030};
         7'd84: e = {21'h1032, 21'h1032}; 7'd85: e = {21'h1036, 21'h1037};
         7'd86: e = {21'h1039, 21'h1039}; 7'd87: e = {21'h1058, 21'h1059};
         7'd88: e = {21'h1160, 21'h11FF}; 7'd89: e = {21'h1712, 21'h1714};
         7'd90: e = {21'h1732, 21'h1734}; 7'd91: e = {21'h1752, 21'h1753};
         7'd92: e = {21'h1772, 21'h1773}; 7'd93: e = {21'h17B4, 21'h17B5};
         7'd94: e = {21'h17B7, 21'h17BD}; 7'd95: e = {21'h17C6, 21'h17C6};
         7'd96: e = {21'h17C9, 21'h17D3}; 7'd97: e = {21'h17DD, 21'h17DD};
         7'd98: e = {21'h180B, 21'h180D}; 7'd99: e = {21'h18A9, 21'h18A9};
         7'd100: e = {21'h1920, 21'h1922}; 7'd101: e = {21'h1927, 21'h1928};
         7'd102: e = {21'h1932, 21'h1932}; 7'd103: e = {21'h1939, 21'h193B};
         7'd104: e = {21'h200B, 21'h200F}; 7'd105: e = {21'h202A, 21'h202E};
         7'd106: e = {21'h2060, 21'h2063}; 7'd107: e = {21'h206A, 21'h206F};
         7'd108: e = {21'h20D0, 21'h20EA}; 7'd109: e = {21'h302A, 21'h302F};
         7'd110: e = {21'h3099, 21'h309A}; 7'd111: e = {21'hFB1E, 21'hFB1E};
         7'd112: e = {21'hFE00, 21'hFE0F}; 7'd113: e = {21'hFE20, 21'hFE23};
         7'd114: e = {21'hFEFF, 21'hFEFF}; 7'd115: e = {21'hFFF9, 21'hFFFB};
         7'd116: e = {21'h1D167, 21'h1D169}; 7'd117: e = {21'h1D173, 21'h1D182};
         7'd118: e = {21'h1D185, 21'h1D18B}; 7'd119: e = {21'h1D1AA, 21'h1D1AD};
         7'd120: e = {21'hE0001, 21'hE0001}; 7'd121: e = {21'hE0020, 21'hE007F};
         7'd122: e = {21'hE0100, 21'hE01EF};
         default: e = '0;
      endcase
      return e;
   endfunction

endpackage

// ----- rtl/utf8_decode_column_width.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_decode_column_width: UTF-8 decoder with terminal column width
// Decodes a byte stream into code points and reports display width.
// ----------------------------------------------------------------------------
// The decoder front takes one byte per cycle while its queue has room and
// folds it into the current sequence; a finished character or an error word
// goes into a two-entry queue. The width back end pops one entry, bisects
// the 123-interval combining table one probe per cycle (up to 7 probes, then
// a closing check when no interval matches), then holds the result word
// until it is taken. While the queue is full the input is stalled. An
// invalid sequence yields a single error word (code point, length and width
// zero, status one) and decoding resumes as a lead byte with the byte after
// the offending one.
module utf8_decode_column_width #(
   parameter int QueueDepth = u8cw_pkg::QueueDepth
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [7:0]   req_data_byte,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [20:0]       rsp_code_point,
   output logic [2:0]        rsp_seq_bytes,
   output logic signed [2:0] rsp_column_width,
   output logic              rsp_status
);
   import u8cw_pkg::*;

   work_type front_word, head_word;
   logic     front_valid, q_not_empty, q_full, q_pop, accept;

   // hold the byte whenever the queue could not take a result from it
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   u8cw_front u_front (
      .clock(clock), .reset(reset),
      .byte_valid(accept), .byte_data(req_data_byte),
      .work_out(front_word), .work_valid(front_valid)
   );

   u8cw_queue #(.Depth(QueueDepth)) u_queue (
      .clock(clock), .reset(reset),
      .push(front_valid), .push_data(front_word),
      .pop(q_pop), .head(head_word),
      .not_empty(q_not_empty), .full(q_full)
   );

   u8cw_back u_back (
      .clock(clock), .reset(reset),
      .work_valid(q_not_empty), .work_in(head_word), .work_pop(q_pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_code_point(rsp_code_point), .rsp_seq_bytes(rsp_seq_bytes),
      .rsp_column_width(rsp_column_width), .rsp_status(rsp_status)
   );
endmodule
`default_nettype wire

// ----- rtl/u8cw_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8cw_front: UTF-8 sequence decoder
// Gathers bytes into characters and flags malformed sequences.
// ----------------------------------------------------------------------------
module u8cw_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              byte_valid,
   input  wire logic [7:0]        byte_data,
   output u8cw_pkg::work_type     work_out,
   output logic                   work_valid
);
   import u8cw_pkg::*;

   logic [1:0]         pend_ff, pend_in;
   logic [CpWidth-1:0] part_ff, part_in;
   logic [7:0]         lead_ff, lead_in;
   logic [7:0]         second_ff, second_in;
   logic [2:0]         total_ff, total_in;
   logic [2:0]         idx;
   logic [CpWidth-1:0] shifted;

   assign idx     = total_ff - {1'b0, pend_ff};
   assign shifted = {part_ff[CpWidth-7:0], byte_data[5:0]};

   always_comb begin
      pend_in = pend_ff; part_in = part_ff; lead_in = lead_ff;
      second_in = second_ff; total_in = total_ff;
      work_valid = 1'b0;
      work_out = '0;
      if (byte_valid) begin
         if (pend_ff == 2'd0) begin
            lead_in = byte_data;
            if (byte_data < 8'h80) begin
               work_valid = 1'b1;
               work_out.cp = {13'd0, byte_data};
               work_out.len = 3'd1;
               lead_in = '0;
            end else if (byte_data[7:5] == 3'b110 && byte_data[4:1] != 4'd0) begin
               part_in = {16'd0, byte_data[4:0]}; pend_in = 2'd1; total_in = 3'd2;
            end else if (byte_data[7:4] == 4'he) begin
               part_in = {17'd0, byte_data[3:0]}; pend_in = 2'd2; total_in = 3'd3;
            end else if (byte_data[7:3] == 5'h1e && byte_data <= 8'hf4) begin
               part_in = {18'd0, byte_data[2:0]}; pend_in = 2'd3; total_in = 3'd4;
            end else begin
               work_valid = 1'b1; work_out.err = 1'b1; lead_in = '0;
            end
         end else begin
            work_out.err = (byte_data[7:6] != 2'b10);
            if (idx == 3'd1) begin
               if ((lead_ff == 8'he0 && byte_data[7:5] == 3'b100) ||
                   (lead_ff == 8'hed && byte_data[7:5] == 3'b101) ||
                   (lead_ff == 8'hf0 && byte_data[7:4] == 4'h8) ||
                   (lead_ff == 8'hf4 && byte_data > 8'h8f))
                  work_out.err = 1'b1;
               second_in = byte_data;
            end else if (total_ff == 3'd3) begin
               if (lead_ff == 8'hef && second_ff == 8'hbf && byte_data[7:1] == 7'h5f)
                  work_out.err = 1'b1;
            end
            if (work_out.err) begin
               work_valid = 1'b1;
               pend_in = '0; part_in = '0; lead_in = '0; second_in = '0; total_in = '0;
            end else begin
               part_in = shifted;
               pend_in = pend_ff - 2'd1;
               if (pend_ff == 2'd1) begin
                  work_valid = 1'b1;
                  work_out.cp = shifted;
                  work_out.len = total_ff;
                  pend_in = '0; part_in = '0; lead_in = '0; second_in = '0;
                  total_in = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0; part_ff <= '0; lead_ff <= '0; second_ff <= '0; total_ff <= '0;
      end else begin
         pend_ff <= pend_in; part_ff <= part_in; lead_ff <= lead_in;
         second_ff <= second_in; total_ff <= total_in;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/u8cw_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8cw_queue: small FIFO between decoder and width lookup
// Holds decoded characters while the lookup runs.
// ----------------------------------------------------------------------------
module u8cw_queue #(
   parameter int Depth = u8cw_pkg::QueueDepth
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  u8cw_pkg::work_type     push_data,
   input  wire logic              pop,
   output u8cw_pkg::work_type     head,
   output logic                   not_empty,
   output logic                   full
);
   import u8cw_pkg::*;
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   work_type          mem_ff [Depth];
   logic [AW-1:0]     rd_ff, rd_in, wr_ff, wr_in;
   logic [AW:0]       cnt_ff, cnt_in;

   function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
      return (p == AW'(Depth - 1)) ? '0 : p + 1'b1;
   endfunction

   assign not_empty = (cnt_ff != '0);
   assign full      = (cnt_ff == (AW+1)'(Depth));
   assign head      = mem_ff[rd_ff];

   always_comb begin
      rd_in  = pop  ? bump(rd_ff) : rd_ff;
      wr_in  = push ? bump(wr_ff) : wr_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0; wr_ff <= '0; cnt_ff <= '0;
      end else begin
         rd_ff <= rd_in; wr_ff <= wr_in; cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/u8cw_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8cw_back: column width lookup
// Bisects the combining table one probe a cycle and holds the result word.
// ----------------------------------------------------------------------------
module u8cw_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              work_valid,
   input  u8cw_pkg::work_type     work_in,
   output logic                   work_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [20:0]            rsp_code_point,
   output logic [2:0]             rsp_seq_bytes,
   output logic signed [2:0]      rsp_column_width,
   output logic                   rsp_status
);
   import u8cw_pkg::*;

   back_state_type     st_ff, st_in;
   work_type           cur_ff, cur_in;
   logic [RomIdxBits:0] lo_ff, lo_in, hi_ff, hi_in;
   logic               zw_ff, zw_in;
   logic [RomIdxBits:0] mid;
   logic [2*CpWidth-1:0] ent;
   logic [CpWidth-1:0] cp;
   logic               wide;
   logic [2:0]         width;

   assign cp  = cur_ff.cp;
   assign mid = (lo_ff + hi_ff) >> 1;
   assign ent = rom_entry(mid[RomIdxBits-1:0]);

   always_comb begin
      wide = cp >= 21'h1100 &&
         (cp <= 21'h115f || cp == 21'h2329 || cp == 21'h232a ||
          (cp >= 21'h2e80 && cp <= 21'ha4cf && cp != 21'h303f) ||
          (cp >= 21'hac00 && cp <= 21'hd7a3) ||
          (cp >= 21'hf900 && cp <= 21'hfaff) ||
          (cp >= 21'hfe30 && cp <= 21'hfe6f) ||
          (cp >= 21'hff00 && cp <= 21'hff60) ||
          (cp >= 21'hffe0 && cp <= 21'hffe6) ||
          (cp >= 21'h20000 && cp <= 21'h2fffd) ||
          (cp >= 21'h30000 && cp <= 21'h3fffd));
      if (cur_ff.err || cp == '0) width = 3'd0;
      else if (cp < 21'h20 || (cp >= 21'h7f && cp < 21'ha0)) width = 3'b111;
      else if (zw_ff) width = 3'd0;
      else width = wide ? 3'd2 : 3'd1;
   end

   always_comb begin
      st_in = st_ff; cur_in = cur_ff; lo_in = lo_ff; hi_in = hi_ff; zw_in = zw_ff;
      work_pop = 1'b0;
      case (st_ff)
         BK_IDLE: begin
            if (work_valid) begin
               work_pop = 1'b1; cur_in = work_in; zw_in = 1'b0;
               lo_in = '0; hi_in = (RomIdxBits+1)'(RomDepth);
               st_in = BK_SEARCH;
            end
         end
         BK_SEARCH: begin
            if (lo_ff >= hi_ff) st_in = BK_DONE;
            else if (cp > ent[CpWidth-1:0]) lo_in = mid + 1'b1;
            else if (cp < ent[2*CpWidth-1:CpWidth]) hi_in = mid;
            else begin zw_in = 1'b1; st_in = BK_DONE; end
         end
         BK_DONE: begin
            if (!rsp_stall) st_in = BK_IDLE;
         end
         default: st_in = BK_IDLE;
      endcase
   end

   assign rsp_valid        = (st_ff == BK_DONE);
   assign rsp_code_point   = cur_ff.cp;
   assign rsp_seq_bytes    = cur_ff.len;
   assign rsp_column_width = width;
   assign rsp_status       = cur_ff.err;

   always_ff @(posedge clock) begin
      if (reset) st_ff <= BK_IDLE;
      else st_ff <= st_in;
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in; lo_ff <= lo_in; hi_ff <= hi_in; zw_ff <= zw_in;
   end
endmodule
`default_nettype wire

// ----- test/utf8_decode_column_width_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_decode_column_width_test: self-checking bench for the UTF-8 decoder
// Feeds directed and random byte streams with random gaps and stalls, keeps
// its own decoder and width predictor, and checks every result word in order.
// ----------------------------------------------------------------------------

// Expected result word for one decoded character or one error.
typedef struct {
   logic [20:0]       cp;
   logic [2:0]        len;
   logic signed [2:0] width;
   logic              err;
} char_word_type;

class utf8_scoreboard;
   char_word_type pending_chars[$];
   int unsigned mismatches;
   // decoder state
   logic [1:0]  awaited;
   logic [20:0] gathered;
   logic [7:0]  lead;
   logic [7:0]  second;
   logic [2:0]  seq_len;
   logic [20:0] zw_lo[123];
   logic [20:0] zw_hi[123];

   function new();
      logic [41:0] e;
      for (int i = 0; i < 123; i++) begin
         e = u8cw_pkg::rom_entry(i[6:0]);
         zw_lo[i] = e[41:21];
         zw_hi[i] = e[20:0];
      end
      clear_seq();
      mismatches = 0;
   endfunction

   function void clear_seq();
      awaited = 0; gathered = 0; lead = 0; second = 0; seq_len = 0;
   endfunction

   // linear scan; the block bisects, so the two must agree
   function bit is_combining(logic [20:0] cp);
      for (int i = 0; i < 123; i++)
         if (cp >= zw_lo[i] && cp <= zw_hi[i]) return 1;
      return 0;
   endfunction

   function logic signed [2:0] columns(logic [20:0] cp);
      bit wide;
      if (cp == 0) return 3'sd0;
      if (cp < 21'h20 || (cp >= 21'h7f && cp < 21'ha0)) return -3'sd1;
      if (is_combining(cp)) return 3'sd0;
      wide = cp >= 21'h1100 &&
         (cp <= 21'h115f || cp == 21'h2329 || cp == 21'h232a ||
          (cp >= 21'h2e80 && cp <= 21'ha4cf && cp != 21'h303f) ||
          (cp >= 21'hac00 && cp <= 21'hd7a3) ||
          (cp >= 21'hf900 && cp <= 21'hfaff) ||
          (cp >= 21'hfe30 && cp <= 21'hfe6f) ||
          (cp >= 21'hff00 && cp <= 21'hff60) ||
          (cp >= 21'hffe0 && cp <= 21'hffe6) ||
          (cp >= 21'h20000 && cp <= 21'h2fffd) ||
          (cp >= 21'h30000 && cp <= 21'h3fffd));
      return wide ? 3'sd2 : 3'sd1;
   endfunction

   function void push_error();
      char_word_type w;
      w.cp = 0; w.len = 0; w.width = 0; w.err = 1;
      pending_chars.push_back(w);
      clear_seq();
   endfunction

   function void push_char(logic [20:0] cp, logic [2:0] len);
      char_word_type w;
      w.cp = cp; w.len = len; w.width = columns(cp); w.err = 0;
      pending_chars.push_back(w);
      clear_seq();
   endfunction

   // fold one accepted byte into the predicted decoder state
   function void note_byte(logic [7:0] b);
      if (awaited == 0) begin
         if (b < 8'h80) begin
            push_char({13'd0, b}, 3'd1);
            return;
         end
         if ((b & 8'he0) == 8'hc0) begin
            if ((b & 8'hfe) == 8'hc0) begin
               push_error();
               return;
            end
            gathered = b & 8'h1f; awaited = 1; seq_len = 2;
         end else if ((b & 8'hf0) == 8'he0) begin
            gathered = b & 8'h0f; awaited = 2; seq_len = 3;
         end else if ((b & 8'hf8) == 8'hf0 && b <= 8'hf4) begin
            gathered = b & 8'h07; awaited = 3; seq_len = 4;
         end else begin
            push_error();
            return;
         end
         lead = b;
         return;
      end
      if ((b & 8'hc0) != 8'h80) begin
         push_error();
         return;
      end
      if (seq_len - awaited == 1) begin
         if ((lead == 8'he0 && (b & 8'he0) == 8'h80) ||
             (lead == 8'hed && (b & 8'he0) == 8'ha0) ||
             (lead == 8'hf0 && (b & 8'hf0) == 8'h80) ||
             (lead == 8'hf4 && b > 8'h8f)) begin
            push_error();
            return;
         end
         second = b;
      end else if (seq_len == 3) begin
         if (lead == 8'hef && second == 8'hbf && (b & 8'hfe) == 8'hbe) begin
            push_error();
            return;
         end
      end
      gathered = {gathered[14:0], b[5:0]};
      awaited = awaited - 1;
      if (awaited == 0) push_char(gathered, seq_len);
   endfunction

   function void check_word(logic [20:0] cp, logic [2:0] len,
                            logic signed [2:0] width, logic err);
      char_word_type w;
      if (pending_chars.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected word: cp=%h len=%0d w=%0d err=%b", cp, len, width, err);
         return;
      end
      w = pending_chars.pop_front();
      if (w.cp !== cp || w.len !== len || w.width !== width || w.err !== err) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: exp cp=%h len=%0d w=%0d err=%b, got cp=%h len=%0d w=%0d err=%b",
                     w.cp, w.len, w.width, w.err, cp, len, width, err);
      end
   endfunction
endclass

module utf8_decode_column_width_test;
   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [7:0]        req_data_byte;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [20:0]       rsp_code_point;
   logic [2:0]        rsp_seq_bytes;
   logic signed [2:0] rsp_column_width;
   logic              rsp_status;

   utf8_scoreboard decode_board;
   bit             calm;   // no idling on either side while set

   utf8_decode_column_width uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_code_point(rsp_code_point), .rsp_seq_bytes(rsp_seq_bytes),
      .rsp_column_width(rsp_column_width), .rsp_status(rsp_status)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Send one byte: optionally idle first, then hold it until accepted.
   task automatic send_byte(input logic [7:0] b);
      while (!calm && $urandom_range(99) < 35) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid     <= 1;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_board.note_byte(b);
   endtask

   task automatic send_cp(input logic [20:0] cp);
      if (cp < 21'h80) send_byte(cp[7:0]);
      else if (cp < 21'h800) begin
         send_byte({3'b110, cp[10:6]}); send_byte({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
         send_byte({4'b1110, cp[15:12]}); send_byte({2'b10, cp[11:6]});
         send_byte({2'b10, cp[5:0]});
      end else begin
         send_byte({5'b11110, cp[20:18]}); send_byte({2'b10, cp[17:12]});
         send_byte({2'b10, cp[11:6]}); send_byte({2'b10, cp[5:0]});
      end
   endtask

   // Pick a code point biased toward interesting regions.
   function automatic logic [20:0] pick_cp();
      logic [41:0] e;
      case ($urandom_range(7))
         0: return 21'($urandom_range(8'hff));
         1: return 21'($urandom_range(21'h7ff, 21'h80));
         2: begin
            e = u8cw_pkg::rom_entry(7'($urandom_range(122)));
            return 21'(e[41:21] + $urandom_range(2) - 1);
         end
         3: return 21'($urandom_range(21'h3fffd, 21'h1100));
         4: return 21'($urandom_range(21'hffff, 21'hf000));
         5: return 21'($urandom_range(21'h10ffff, 21'h10000));
         default: return 21'($urandom_range(21'h10ffff));
      endcase
   endfunction

   // result side: random stalls, check every accepted word
   initial begin
      rsp_stall = 1;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall)
            decode_board.check_word(rsp_code_point, rsp_seq_bytes,
                                    rsp_column_width, rsp_status);
         rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 35);
      end
   end

   initial begin
      logic [7:0] directed[$];
      decode_board = new();
      calm = 0;
      reset = 1;
      req_valid = 0;
      req_data_byte = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // NUL, DEL, 0x7F boundary, C1 control, stray continuation, C0/C1/F5/FF leads,
      // overlongs, surrogate, U+FFFE, above U+10FFFF, lead cutting a sequence,
      // largest scalar value
      directed = '{8'h00, 8'h7f, 8'hc2, 8'h80, 8'h80, 8'hc0, 8'hc1, 8'hf5, 8'hff,
                   8'he0, 8'h9f, 8'hed, 8'ha0, 8'hef, 8'hbf, 8'hbe,
                   8'hf0, 8'h8f, 8'hf4, 8'h90, 8'he3, 8'h41,
                   8'hf4, 8'h8f, 8'hbf, 8'hbf};
      foreach (directed[i]) send_byte(directed[i]);

      // pause until the block has drained
      req_valid <= 0;
      while (decode_board.pending_chars.size() != 0) @(posedge clock);

      for (int n = 0; n < 230; n++) begin
         calm = (n >= 80 && n < 120);   // a stretch with no idling
         if ($urandom_range(99) < 80) send_cp(pick_cp());
         else send_byte(8'($urandom_range(255)));
      end
      calm = 0;
      req_valid <= 0;
      while (decode_board.pending_chars.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (decode_board.mismatches == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end
endmodule
